/* hdl/cdcm_pkg.sv */
// Shared types and constants for the calibrated DAC code mapper.
`timescale 1ns / 1ps
package cdcm_pkg;

  localparam int THR_W   = 24;
  localparam int MULT_W  = 18;
  localparam int CUR_W   = 24;
  localparam int PT_W    = 7;
  localparam int RES_W   = 16;
  localparam int STEP_W  = 24;
  localparam int GAIN_W  = 20;
  localparam int CODE_W  = 12;
  localparam int TIDX_W  = 12;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 24;

  localparam logic [CODE_W-1:0] CODE_MAX = 12'd4095;
  localparam logic [THR_W-1:0]  VOLT_MAX = 24'hFFFFFF;

  localparam logic [RES_W-1:0]  RES_RESET  = 16'd410;
  localparam logic [STEP_W-1:0] STEP_RESET = 24'd126724;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd319688;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  localparam logic [CIDX_W-1:0] REG_RESISTANCE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_VSTEP      = 2'd1;
  localparam logic [CIDX_W-1:0] REG_DAC_GAIN   = 2'd2;

  typedef struct packed {
    logic [THR_W-1:0]  thr;
    logic [MULT_W-1:0] mult;
  } tbl_entry_t;

endpackage

/* hdl/cdcm_table_ram.sv */
// Calibration table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module cdcm_table_ram
  import cdcm_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  tbl_entry_t               wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output tbl_entry_t               rd_data
);

  tbl_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/calibrated_dac_code_mapper.sv */
// Top level of the calibrated DAC code mapper: control sequencer and datapath.
`timescale 1ns / 1ps
// Usage
//   cfg channel: a transfer writes resistance (index 0), voltage step (1) or
//   DAC gain (2); other indexes are dropped. It is always ready and should
//   only be used while the block is idle.
//   in channel: opcode 0 writes one table entry in the transfer cycle and
//   gives no result; opcode 1 converts a sample and gives one result.
//   out channel: dac_code, clipped and chosen_slot from an output register.
// Sequence and throughput
//   A table write is taken in the idle state and leaves the block idle. A
//   conversion passes ST_MUL, ST_SUM and ST_FIRST; below the first threshold
//   it goes on to ST_SCALE1, else ST_LAST, where a voltage above the last
//   threshold goes to ST_SCALE1 and any other starts the binary search of at
//   most clog2(TABLE_DEPTH)+1 probes; then ST_SCALE2 and ST_DONE follow.
//   The probe loop dominates: each probe is one read of the table memory,
//   whose registered data steers the next read address. One item is in
//   work at a time; the next is taken in the cycle after a result is loaded.
// Reset and stall
//   Reset restores the register defaults and empties the output register;
//   the table keeps its contents, which are undefined until written. While
//   the receiver stalls, the result is held and a new item is still taken;
//   a conversion that finishes meanwhile waits until the register frees.
module calibrated_dac_code_mapper
  import cdcm_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096,
  parameter int NUM_POINTS  = 65
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CDATA_W-1:0]       cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     opcode,
  input  logic [TIDX_W-1:0]        table_index,
  input  logic [THR_W-1:0]         table_threshold,
  input  logic [MULT_W-1:0]        table_multiplier,
  input  logic signed [CUR_W-1:0]  current_sample,
  input  logic [PT_W-1:0]          point_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CODE_W-1:0]        dac_code,
  output logic                     clipped,
  output logic [TIDX_W-1:0]        chosen_slot
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [ADDR_W:0]   DEPTH_X   = (ADDR_W + 1)'(TABLE_DEPTH);
  localparam logic [PT_W-1:0]   PT_LAST   = PT_W'(NUM_POINTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_SUM, ST_FIRST, ST_LAST, ST_SEARCH,
    ST_SCALE1, ST_SCALE2, ST_DONE
  } state_t;

  state_t state;

  logic [RES_W-1:0]  resistance;
  logic [STEP_W-1:0] vstep;
  logic [GAIN_W-1:0] gain;

  logic signed [CUR_W-1:0] cur;
  logic [PT_W-1:0]         pt;
  logic signed [40:0]      res_prod;
  logic [30:0]             step_prod;
  logic [THR_W-1:0]        volt;
  logic                    clip;
  logic [ADDR_W:0]         lo;
  logic [ADDR_W:0]         hp1;
  logic [ADDR_W-1:0]       mid;
  logic [ADDR_W-1:0]       slot;
  logic [41:0]             p1;
  logic [40:0]             plo;
  logic [40:0]             phi;

  logic                  in_xfer;
  logic                  wr_en;
  logic [ADDR_W-1:0]     rd_addr;
  tbl_entry_t            rd_data;
  tbl_entry_t            wr_entry;

  logic signed [42:0]    vsum;
  logic [31:0]           vq;
  logic                  ge;
  logic [ADDR_W:0]       lo_n;
  logic [ADDR_W:0]       hp1_n;
  logic [ADDR_W+1:0]     mid_sum;
  logic [ADDR_W-1:0]     mid_n;
  logic [ADDR_W-1:0]     slot_n;
  logic                  more;
  logic [61:0]           total;
  logic                  start_mid_sel;
  logic [ADDR_W-1:0]     start_mid;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign wr_en     = in_xfer && (opcode == OP_WRITE)
                     && ({20'd0, table_index} < 32'(TABLE_DEPTH));
  assign wr_entry  = '{thr: table_threshold, mult: table_multiplier};

  cdcm_table_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(table_index)),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Voltage in units of 2^-30 V, then truncated to Q4.20 with saturation.
  assign vsum = {{2{res_prod[40]}}, res_prod} + {2'b00, step_prod, 10'd0};
  assign vq   = vsum[41:10];

  // One probe of the lower-bound search, evaluated on the registered read data.
  assign ge      = (rd_data.thr >= volt);
  assign lo_n    = ge ? lo : ({1'b0, mid} + 1'b1);
  assign hp1_n   = ge ? {1'b0, mid} : hp1;
  assign mid_sum = {1'b0, lo_n} + {1'b0, hp1_n} - 1'b1;
  assign mid_n   = mid_sum[ADDR_W:1];
  assign more    = (lo_n < hp1_n);
  assign slot_n  = (lo_n >= DEPTH_X) ? LAST_SLOT : lo_n[ADDR_W-1:0];

  assign start_mid = LAST_SLOT >> 1;
  assign start_mid_sel = (volt <= rd_data.thr);

  assign total = {phi, 21'd0} + {21'd0, plo};

  always_comb begin
    rd_addr = '0;
    unique case (state)
      ST_SUM:    rd_addr = '0;
      ST_FIRST:  rd_addr = (volt < rd_data.thr) ? '0 : LAST_SLOT;
      ST_LAST:   rd_addr = start_mid_sel ? start_mid : LAST_SLOT;
      ST_SEARCH: rd_addr = more ? mid_n : slot_n;
      default:   rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resistance <= RES_RESET;
      vstep      <= STEP_RESET;
      gain       <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RESISTANCE: resistance <= cfg_data[RES_W-1:0];
        REG_VSTEP:      vstep      <= cfg_data[STEP_W-1:0];
        REG_DAC_GAIN:   gain       <= cfg_data[GAIN_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In ST_DONE the output register is handled by the load below.
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer && (opcode == OP_CONVERT)) begin
            cur   <= current_sample;
            pt    <= (point_index > PT_LAST) ? PT_LAST : point_index;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          res_prod  <= $signed({1'b0, resistance}) * cur;
          step_prod <= pt * vstep;
          state     <= ST_SUM;
        end
        ST_SUM: begin
          if (vsum[42]) begin
            volt <= '0;
            clip <= 1'b1;
          end else if (vq[31:THR_W] != '0) begin
            volt <= VOLT_MAX;
            clip <= 1'b1;
          end else begin
            volt <= vq[THR_W-1:0];
            clip <= 1'b0;
          end
          state <= ST_FIRST;
        end
        ST_FIRST: begin
          // Below the first threshold the first entry is used outright.
          if (volt < rd_data.thr) begin
            slot  <= '0;
            state <= ST_SCALE1;
          end else begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          if (start_mid_sel) begin
            lo    <= '0;
            hp1   <= DEPTH_X;
            mid   <= start_mid;
            state <= ST_SEARCH;
          end else begin
            slot  <= LAST_SLOT;
            state <= ST_SCALE1;
          end
        end
        ST_SEARCH: begin
          lo  <= lo_n;
          hp1 <= hp1_n;
          mid <= mid_n;
          if (!more) begin
            slot  <= slot_n;
            state <= ST_SCALE1;
          end
        end
        ST_SCALE1: begin
          p1    <= volt * rd_data.mult;
          state <= ST_SCALE2;
        end
        ST_SCALE2: begin
          plo   <= p1[20:0] * gain;
          phi   <= p1[41:21] * gain;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            if (total[61:56] != '0) begin
              dac_code <= CODE_MAX;
              clipped  <= 1'b1;
            end else begin
              dac_code <= total[55:44];
              clipped  <= clip;
            end
            chosen_slot <= TIDX_W'(slot);
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result appeared without a finished conversion");

  a_search_open: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (lo < hp1) && ({1'b0, mid} < hp1) && ({1'b0, mid} >= lo))
    else $error("probe outside the open search interval");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && !out_ready) |=> (state == ST_DONE) && out_valid)
    else $error("finished conversion lost while output stalled");

endmodule
